// ===== hdl/wdpr_pkg.sv =====
// Shared types, constants and functions of the wall-distance pose reset block.
// Used by every module in hdl/; depends on nothing else.

package wdpr_pkg;

  // Defaults of the top-level parameters.
  localparam int COS_ENTRIES_DEF = 256;
  localparam int FRACTION_BITS_DEF = 8;

  // Fixed field widths.
  localparam int POS_W = 16;
  localparam int HEAD_W = 32;
  localparam int MM_W = 14;
  localparam int CFG_W = 15;
  localparam int OFF_W = 13;
  localparam int TILT_W = 13;
  localparam int COS_W = 17;
  localparam int CORR_W = 15;
  localparam int THETA_W = 16;
  localparam int CFG_IDX_W = 3;

  // Heading reduction: a heading is split into a signed upper half and an
  // unsigned lower half, and 2^16 is congruent to HEAD_HI_MOD modulo a full turn.
  localparam int TURN_CDEG = 36000;
  localparam int QUARTER_CDEG = 9000;
  localparam int HALF_QUARTER_CDEG = 4500;
  localparam int HEAD_HI_MOD = 29536;
  localparam int HEAD_R_W = 30;
  localparam int HEAD_Q_W = 15;
  localparam int HEAD_REC_S = 46;
  localparam logic [63:0] HEAD_REC_M64 =
    ((64'd1 << HEAD_REC_S) + 64'(TURN_CDEG - 1)) / 64'(TURN_CDEG);
  localparam logic [30:0] HEAD_REC_M = HEAD_REC_M64[30:0];

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // Register reset values (distances and offsets with eight fraction bits, tilt in hundredths of a degree).
  localparam logic [CFG_W-1:0] FHW_RST = 15'd18432;
  localparam logic [CFG_W-1:0] MAX_DIST_RST = 15'd11520;
  localparam logic [CFG_W-1:0] LONG_DIST_RST = 15'd17408;
  localparam logic [OFF_W-1:0] OFF_LEFT_RST = 13'd1344;
  localparam logic [OFF_W-1:0] OFF_RIGHT_RST = 13'd1344;
  localparam logic [OFF_W-1:0] OFF_BACK_RST = 13'd1024;
  localparam logic [OFF_W-1:0] OFF_FRONT_RST = 13'd1280;
  localparam logic [TILT_W-1:0] MAX_TILT_RST = 13'd3000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIELD_HALF_WIDTH = 3'd0,
    CFG_MAX_RESET_DIST   = 3'd1,
    CFG_LONG_RESET_DIST  = 3'd2,
    CFG_OFFSET_LEFT      = 3'd3,
    CFG_OFFSET_RIGHT     = 3'd4,
    CFG_OFFSET_BACK      = 3'd5,
    CFG_OFFSET_FRONT     = 3'd6,
    CFG_MAX_TILT         = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SENS_LEFT  = 2'd0,
    SENS_RIGHT = 2'd1,
    SENS_BACK  = 2'd2,
    SENS_FRONT = 2'd3
  } sensor_e;

  // What one axis lane needs about an item.
  typedef struct packed {
    logic                    gate;    // tilt passed, position non-zero, sensor enabled
    logic                    side;    // 1: wall on the positive side
    logic [CFG_W-1:0]        limit;
    logic [OFF_W-1:0]        offset;
    logic [MM_W-1:0]         mm;
    logic signed [POS_W-1:0] pos;
  } lane_t;

  // Sensor facing the wall on the given side of an axis for a heading quarter.
  function automatic sensor_e axis_sensor(input logic y_axis, input logic [1:0] quarter,
                                          input logic side);
    sensor_e neg;
    sensor_e pos;
    unique case ({y_axis, quarter})
      3'b000: begin neg = SENS_LEFT;  pos = SENS_RIGHT; end
      3'b001: begin neg = SENS_BACK;  pos = SENS_FRONT; end
      3'b010: begin neg = SENS_RIGHT; pos = SENS_LEFT;  end
      3'b011: begin neg = SENS_FRONT; pos = SENS_BACK;  end
      3'b100: begin neg = SENS_BACK;  pos = SENS_FRONT; end
      3'b101: begin neg = SENS_RIGHT; pos = SENS_LEFT;  end
      3'b110: begin neg = SENS_FRONT; pos = SENS_BACK;  end
      default: begin neg = SENS_LEFT; pos = SENS_RIGHT; end
    endcase
    return side ? pos : neg;
  endfunction

  // Cosine in Q16 of an angle given in Q30 radians, by a Taylor series.
  // Evaluated only at elaboration to fill the cosine table.
  function automatic logic [COS_W-1:0] cos_q16(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2 = (x * x) >> 30;
    term = 64'd1 << 30;
    sum = term;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return COS_W'((sum + (64'd1 << 13)) >> 14);
  endfunction

endpackage

// ===== hdl/wdpr_heading.sv =====
// Three-stage heading wrap: reduces a signed heading in hundredths of a degree
// to 0..35999. Uses wdpr_pkg for widths and the reciprocal constant.

module wdpr_heading (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [wdpr_pkg::HEAD_W-1:0]       heading_i,
  output logic [wdpr_pkg::THETA_W-1:0]      theta_o
);

  logic [15:0]                      hi_mod;
  logic [wdpr_pkg::HEAD_R_W-1:0]    r1_d, r1_q, r2_q;
  logic [61:0]                      rec_prod;
  logic [wdpr_pkg::HEAD_Q_W-1:0]    quot_d, quot_q;
  logic [wdpr_pkg::HEAD_R_W-1:0]    rem_full;
  logic [wdpr_pkg::THETA_W-1:0]     theta_d, theta_q;

  // A negative upper half plus a full turn, taken modulo 2^16, is its
  // non-negative residue.
  assign hi_mod = heading_i[31] ? (heading_i[31:16] + 16'(wdpr_pkg::TURN_CDEG))
                                : heading_i[31:16];
  assign r1_d = wdpr_pkg::HEAD_R_W'({14'd0, hi_mod} * 30'(wdpr_pkg::HEAD_HI_MOD))
              + wdpr_pkg::HEAD_R_W'(heading_i[15:0]);

  assign rec_prod = {1'b0, r1_q} * {31'd0, wdpr_pkg::HEAD_REC_M};
  assign quot_d = wdpr_pkg::HEAD_Q_W'(rec_prod >> wdpr_pkg::HEAD_REC_S);

  assign rem_full = r2_q
                  - wdpr_pkg::HEAD_R_W'({15'd0, quot_q} * 30'(wdpr_pkg::TURN_CDEG));
  assign theta_d = rem_full[wdpr_pkg::THETA_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q <= r1_d;
      r2_q <= r1_q;
      quot_q <= quot_d;
      theta_q <= theta_d;
    end
  end

  assign theta_o = theta_q;

endmodule

// ===== hdl/wdpr_cos_rom.sv =====
// Cosine table over 0..45 degrees in Q16 with a registered read port.
// Entries are built at elaboration by wdpr_pkg::cos_q16.

module wdpr_cos_rom #(
  parameter int COS_TABLE_ENTRIES = wdpr_pkg::COS_ENTRIES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [$clog2(COS_TABLE_ENTRIES)-1:0] idx_i,
  output logic [wdpr_pkg::COS_W-1:0]           cos_o
);

  logic [wdpr_pkg::COS_W-1:0] rom [COS_TABLE_ENTRIES];
  logic [wdpr_pkg::COS_W-1:0] cos_q;

  for (genvar k = 0; k < COS_TABLE_ENTRIES; k++) begin : g_entry
    localparam logic [63:0] ANGLE =
      (64'(k) * wdpr_pkg::PI_Q30) / (64'd4 * 64'(COS_TABLE_ENTRIES - 1));
    assign rom[k] = wdpr_pkg::cos_q16(ANGLE);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= rom[idx_i];
    end
  end

  assign cos_o = cos_q;

endmodule

// ===== hdl/wdpr_axis.sv =====
// One axis lane: millimetre to inch conversion, range check, cosine scaling
// and wall-relative position with saturation. Four register stages; uses wdpr_pkg.

module wdpr_axis #(
  parameter int FRACTION_BITS = wdpr_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  wdpr_pkg::lane_t                    lane_i,
  input  logic [wdpr_pkg::COS_W-1:0]         cos_i,
  input  logic [wdpr_pkg::CFG_W-1:0]         fhw_i,
  output logic signed [wdpr_pkg::POS_W-1:0]  pos_o,
  output logic                               hit_o
);

  localparam int NUM_W = $clog2(16383 * (5 << FRACTION_BITS) + 64);
  localparam int D_W = NUM_W - 6;
  localparam int REC_S = NUM_W + 7;
  localparam logic [63:0] REC_M64 = ((64'd1 << REC_S) + 64'd126) / 64'd127;
  localparam logic [NUM_W:0] REC_M = REC_M64[NUM_W:0];
  localparam logic [NUM_W-1:0] SCALE = NUM_W'(5 << FRACTION_BITS);
  localparam int SUM_W = 19;

  wdpr_pkg::lane_t                  s5_q, s6_q, s7_q;
  logic [NUM_W-1:0]                 num_d, num_q;
  logic [2*NUM_W:0]                 rec_prod;
  logic [D_W-1:0]                   dist_d, dist_q;
  logic [31:0]                      corr_prod;
  logic [wdpr_pkg::CORR_W-1:0]      corr_d, corr_q;
  logic                             hit_d, hit_q;
  logic signed [SUM_W-1:0]          wall_sum;
  logic signed [wdpr_pkg::POS_W-1:0] pos_d, pos_q;
  logic                             hit8_q;

  // Rounded mm * 2^F / 25.4, the division by 127 done by a reciprocal.
  assign num_d = NUM_W'(NUM_W'(lane_i.mm) * SCALE) + NUM_W'(63);
  assign rec_prod = {{NUM_W{1'b0}}, num_q} * {{NUM_W{1'b0}}, REC_M};
  assign dist_d = D_W'(rec_prod >> REC_S);

  // Only a reading below the 15-bit limit is scaled, so its low bits suffice.
  assign hit_d = s6_q.gate && (dist_q < D_W'(s6_q.limit));
  assign corr_prod = {17'd0, dist_q[wdpr_pkg::CORR_W-1:0]} * {15'd0, cos_i} + 32'd32768;
  assign corr_d = corr_prod[30:16];

  always_comb begin
    if (s7_q.side) begin
      wall_sum = SUM_W'(signed'({1'b0, fhw_i})) - SUM_W'(signed'({1'b0, corr_q}))
               - SUM_W'(signed'({1'b0, s7_q.offset}));
    end else begin
      wall_sum = SUM_W'(signed'({1'b0, corr_q})) + SUM_W'(signed'({1'b0, s7_q.offset}))
               - SUM_W'(signed'({1'b0, fhw_i}));
    end
    priority if (!hit_q) begin
      pos_d = s7_q.pos;
    end else if (wall_sum > SUM_W'(32767)) begin
      pos_d = 16'sh7FFF;
    end else if (wall_sum < -SUM_W'(32768)) begin
      pos_d = -16'sh8000;
    end else begin
      pos_d = wall_sum[wdpr_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_q <= lane_i;
      num_q <= num_d;
      s6_q <= s5_q;
      dist_q <= dist_d;
      s7_q <= s6_q;
      hit_q <= hit_d;
      corr_q <= corr_d;
      pos_q <= pos_d;
      hit8_q <= hit_q;
    end
  end

  assign pos_o = pos_q;
  assign hit_o = hit8_q;

endmodule

// ===== hdl/wall_distance_pose_reset.sv =====
// Top level of the wall-distance pose reset block: configuration registers,
// heading quarter and tilt logic, pipeline control. Uses wdpr_pkg, wdpr_heading,
// wdpr_cos_rom and wdpr_axis.
//
// The block is an eight-stage pipeline with its result on the output registers;
// while the output is not stalled a new item may enter at every cycle, so the
// sustained rate is one item per clock. The depth is set by the heading wrap
// (three stages, one reciprocal multiply), the tilt-to-index reciprocal, the
// cosine table read and the per-axis conversion and scaling multipliers. While
// a result waits on the output with stall_i high the whole pipeline holds and
// stall_o is raised; nothing is lost or repeated. Configuration must be written
// only while no item is in flight.

module wall_distance_pose_reset #(
  parameter int COS_TABLE_ENTRIES = wdpr_pkg::COS_ENTRIES_DEF,
  parameter int FRACTION_BITS = wdpr_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wdpr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wdpr_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  logic signed [wdpr_pkg::POS_W-1:0]   pose_x_i,
  input  logic signed [wdpr_pkg::POS_W-1:0]   pose_y_i,
  input  logic signed [wdpr_pkg::HEAD_W-1:0]  heading_cdeg_i,
  input  logic [wdpr_pkg::MM_W-1:0]           dist_left_mm_i,
  input  logic [wdpr_pkg::MM_W-1:0]           dist_right_mm_i,
  input  logic [wdpr_pkg::MM_W-1:0]           dist_back_mm_i,
  input  logic [wdpr_pkg::MM_W-1:0]           dist_front_mm_i,
  input  logic [3:0]                          sensor_enable_i,
  input  logic                                use_long_range_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output logic signed [wdpr_pkg::POS_W-1:0]   new_x_o,
  output logic signed [wdpr_pkg::POS_W-1:0]   new_y_o,
  output logic                                status_o,
  output logic                                x_updated_o,
  output logic                                y_updated_o,
  output logic [1:0]                          facing_quarter_o
);

  localparam int IDX_W = $clog2(COS_TABLE_ENTRIES);
  localparam int IDXN_W = $clog2(4500 * (COS_TABLE_ENTRIES - 1) + 2251);
  localparam int IDX_S = IDXN_W + 13;
  localparam logic [63:0] IDX_M64 = ((64'd1 << IDX_S) + 64'd4499) / 64'd4500;
  localparam logic [IDXN_W:0] IDX_M = IDX_M64[IDXN_W:0];
  localparam int DEPTH = 8;

  typedef struct packed {
    logic signed [wdpr_pkg::POS_W-1:0] pose_x;
    logic signed [wdpr_pkg::POS_W-1:0] pose_y;
    logic [3:0][wdpr_pkg::MM_W-1:0]    mm;
    logic [3:0]                        enable;
    logic                              use_long;
  } item_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] quarter;
  } tag_t;

  // Configuration registers.
  logic [wdpr_pkg::CFG_W-1:0]  fhw_q, max_dist_q, long_dist_q;
  logic [3:0][wdpr_pkg::OFF_W-1:0] offset_q;
  logic [wdpr_pkg::TILT_W-1:0] max_tilt_q;

  logic                        adv;
  logic [DEPTH-1:0]            valid_q;
  item_t                       item_d, item1_q, item2_q, item3_q;
  logic [wdpr_pkg::THETA_W-1:0] theta;

  logic [1:0]                  quarter;
  logic [15:0]                 mag16;
  logic [wdpr_pkg::TILT_W-1:0] mag;
  logic                        tilt_ok;
  logic [wdpr_pkg::CFG_W-1:0]  limit;
  wdpr_pkg::lane_t             lane_x_d, lane_y_d, lane_x_q, lane_y_q;
  logic [IDXN_W-1:0]           idxn_d, idxn_q;
  logic [2*IDXN_W:0]           idx_prod;
  logic [IDX_W-1:0]            idx_d, idx_q;
  logic [wdpr_pkg::COS_W-1:0]  cos_val;
  tag_t                        tag4_q, tag5_q, tag6_q, tag7_q, tag8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fhw_q <= wdpr_pkg::FHW_RST;
      max_dist_q <= wdpr_pkg::MAX_DIST_RST;
      long_dist_q <= wdpr_pkg::LONG_DIST_RST;
      offset_q[wdpr_pkg::SENS_LEFT] <= wdpr_pkg::OFF_LEFT_RST;
      offset_q[wdpr_pkg::SENS_RIGHT] <= wdpr_pkg::OFF_RIGHT_RST;
      offset_q[wdpr_pkg::SENS_BACK] <= wdpr_pkg::OFF_BACK_RST;
      offset_q[wdpr_pkg::SENS_FRONT] <= wdpr_pkg::OFF_FRONT_RST;
      max_tilt_q <= wdpr_pkg::MAX_TILT_RST;
    end else if (cfg_we_i) begin
      unique case (wdpr_pkg::cfg_idx_e'(cfg_idx_i))
        wdpr_pkg::CFG_FIELD_HALF_WIDTH: fhw_q <= cfg_wdata_i;
        wdpr_pkg::CFG_MAX_RESET_DIST:   max_dist_q <= cfg_wdata_i;
        wdpr_pkg::CFG_LONG_RESET_DIST:  long_dist_q <= cfg_wdata_i;
        wdpr_pkg::CFG_OFFSET_LEFT:
          offset_q[wdpr_pkg::SENS_LEFT] <= cfg_wdata_i[wdpr_pkg::OFF_W-1:0];
        wdpr_pkg::CFG_OFFSET_RIGHT:
          offset_q[wdpr_pkg::SENS_RIGHT] <= cfg_wdata_i[wdpr_pkg::OFF_W-1:0];
        wdpr_pkg::CFG_OFFSET_BACK:
          offset_q[wdpr_pkg::SENS_BACK] <= cfg_wdata_i[wdpr_pkg::OFF_W-1:0];
        wdpr_pkg::CFG_OFFSET_FRONT:
          offset_q[wdpr_pkg::SENS_FRONT] <= cfg_wdata_i[wdpr_pkg::OFF_W-1:0];
        wdpr_pkg::CFG_MAX_TILT:
          max_tilt_q <= cfg_wdata_i[wdpr_pkg::TILT_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together; it holds only while a finished
  // result is refused at the output.
  assign adv = !(valid_q[DEPTH-1] && stall_i);
  assign stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[DEPTH-2:0], valid_i};
    end
  end

  assign item_d.pose_x = pose_x_i;
  assign item_d.pose_y = pose_y_i;
  assign item_d.mm[wdpr_pkg::SENS_LEFT] = dist_left_mm_i;
  assign item_d.mm[wdpr_pkg::SENS_RIGHT] = dist_right_mm_i;
  assign item_d.mm[wdpr_pkg::SENS_BACK] = dist_back_mm_i;
  assign item_d.mm[wdpr_pkg::SENS_FRONT] = dist_front_mm_i;
  assign item_d.enable = sensor_enable_i;
  assign item_d.use_long = use_long_range_i;

  wdpr_heading u_heading (
    .clk_i     (clk_i),
    .en_i      (adv),
    .heading_i (heading_cdeg_i),
    .theta_o   (theta)
  );

  // Nearest quarter turn and the size of the tilt from it.
  always_comb begin
    priority if (theta < 16'd4500) begin
      quarter = 2'd0;
      mag16 = theta;
    end else if (theta < 16'd13500) begin
      quarter = 2'd1;
      mag16 = (theta >= 16'd9000) ? theta - 16'd9000 : 16'd9000 - theta;
    end else if (theta < 16'd22500) begin
      quarter = 2'd2;
      mag16 = (theta >= 16'd18000) ? theta - 16'd18000 : 16'd18000 - theta;
    end else if (theta < 16'd31500) begin
      quarter = 2'd3;
      mag16 = (theta >= 16'd27000) ? theta - 16'd27000 : 16'd27000 - theta;
    end else begin
      quarter = 2'd0;
      mag16 = 16'(wdpr_pkg::TURN_CDEG) - theta;
    end
  end

  assign mag = mag16[wdpr_pkg::TILT_W-1:0];
  assign tilt_ok = mag <= max_tilt_q;
  assign limit = item3_q.use_long ? long_dist_q : max_dist_q;
  assign idxn_d = IDXN_W'(32'(mag) * 32'(COS_TABLE_ENTRIES - 1) + 32'd2250);

  always_comb begin
    wdpr_pkg::sensor_e sx;
    wdpr_pkg::sensor_e sy;
    sx = wdpr_pkg::axis_sensor(1'b0, quarter, item3_q.pose_x > 16'sd0);
    sy = wdpr_pkg::axis_sensor(1'b1, quarter, item3_q.pose_y > 16'sd0);

    lane_x_d.gate = tilt_ok && (item3_q.pose_x != 16'sd0) && item3_q.enable[sx];
    lane_x_d.side = item3_q.pose_x > 16'sd0;
    lane_x_d.limit = limit;
    lane_x_d.offset = offset_q[sx];
    lane_x_d.mm = item3_q.mm[sx];
    lane_x_d.pos = item3_q.pose_x;

    lane_y_d.gate = tilt_ok && (item3_q.pose_y != 16'sd0) && item3_q.enable[sy];
    lane_y_d.side = item3_q.pose_y > 16'sd0;
    lane_y_d.limit = limit;
    lane_y_d.offset = offset_q[sy];
    lane_y_d.mm = item3_q.mm[sy];
    lane_y_d.pos = item3_q.pose_y;
  end

  // Table index: rounded |tilt| * (entries - 1) / 4500 by a reciprocal.
  assign idx_prod = {{IDXN_W{1'b0}}, idxn_q} * {{IDXN_W{1'b0}}, IDX_M};
  assign idx_d = IDX_W'(idx_prod >> IDX_S);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      item1_q <= item_d;
      item2_q <= item1_q;
      item3_q <= item2_q;
      lane_x_q <= lane_x_d;
      lane_y_q <= lane_y_d;
      idxn_q <= idxn_d;
      idx_q <= idx_d;
      tag4_q <= '{ok: tilt_ok, quarter: quarter};
      tag5_q <= tag4_q;
      tag6_q <= tag5_q;
      tag7_q <= tag6_q;
      tag8_q <= tag7_q;
    end
  end

  wdpr_cos_rom #(
    .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES)
  ) u_cos_rom (
    .clk_i (clk_i),
    .en_i  (adv),
    .idx_i (idx_q),
    .cos_o (cos_val)
  );

  wdpr_axis #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_axis_x (
    .clk_i  (clk_i),
    .en_i   (adv),
    .lane_i (lane_x_q),
    .cos_i  (cos_val),
    .fhw_i  (fhw_q),
    .pos_o  (new_x_o),
    .hit_o  (x_updated_o)
  );

  wdpr_axis #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_axis_y (
    .clk_i  (clk_i),
    .en_i   (adv),
    .lane_i (lane_y_q),
    .cos_i  (cos_val),
    .fhw_i  (fhw_q),
    .pos_o  (new_y_o),
    .hit_o  (y_updated_o)
  );

  assign valid_o = valid_q[DEPTH-1];
  assign status_o = tag8_q.ok;
  assign facing_quarter_o = tag8_q.quarter;

endmodule

// ===== hdl/wdpr_checker.sv =====
// Port-level checks of wall_distance_pose_reset, attached by the bind below.
// Depends on wdpr_pkg for widths only.

module wdpr_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               stall_o,
  input logic                               valid_o,
  input logic                               stall_i,
  input logic signed [wdpr_pkg::POS_W-1:0]  new_x_o,
  input logic signed [wdpr_pkg::POS_W-1:0]  new_y_o,
  input logic                               status_o,
  input logic                               x_updated_o,
  input logic                               y_updated_o,
  input logic [1:0]                         facing_quarter_o
);

  // A refused result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> $stable(new_x_o) && $stable(new_y_o) && $stable(status_o)
      && $stable(x_updated_o) && $stable(y_updated_o) && $stable(facing_quarter_o))
    else $error("stalled result changed");

  // The input side is held only while a finished result is refused.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without a refused result");

  // A rejected tilt never resets an axis.
  a_tilt_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !status_o |-> !x_updated_o && !y_updated_o)
    else $error("axis reset despite excessive tilt");

endmodule

bind wall_distance_pose_reset wdpr_checker u_wdpr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .stall_o          (stall_o),
  .valid_o          (valid_o),
  .stall_i          (stall_i),
  .new_x_o          (new_x_o),
  .new_y_o          (new_y_o),
  .status_o         (status_o),
  .x_updated_o      (x_updated_o),
  .y_updated_o      (y_updated_o),
  .facing_quarter_o (facing_quarter_o)
);
